### rtl/sha1bc_pkg.sv
// ----------------------------------------------------------------------------
// sha1bc_pkg
// Shared types, constants and helpers for the SHA-1 block compression engine.
// ----------------------------------------------------------------------------
package sha1bc_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;
  localparam int HASH_WORDS  = 5;
  localparam int CNT_W       = $clog2(BLOCK_WORDS);
  localparam int RND_W       = $clog2(ROUNDS);

  // Round boundaries between the four function groups
  localparam int PH1_START = 20;
  localparam int PH2_START = 40;
  localparam int PH3_START = 60;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HASH_WORDS-1:0][WORD_W-1:0] hash_t;

  localparam hash_t INIT_H = '{
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round function group
  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY_A,
    PH_MAJORITY,
    PH_PARITY_B
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_ADD,
    ST_HOLD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic   load_word;
    logic   start;
    logic   init_work;
    logic   round_en;
    phase_t phase;
    logic   add_en;
    logic   out_load;
  } cmd_t;

  function automatic word_t round_const(input phase_t ph);
    word_t k;
    unique case (ph)
      PH_CHOOSE:   k = 32'h5A827999;
      PH_PARITY_A: k = 32'h6ED9EBA1;
      PH_MAJORITY: k = 32'h8F1BBCDC;
      PH_PARITY_B: k = 32'hCA62C1D6;
      default:     k = 32'h5A827999;
    endcase
    return k;
  endfunction

  function automatic word_t round_fn(input phase_t ph, input word_t b, input word_t c,
                                     input word_t d);
    word_t f;
    unique case (ph)
      PH_CHOOSE:   f = (b & c) | (~b & d);
      PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
      default:     f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

### rtl/sha1bc_in_if.sv
// ----------------------------------------------------------------------------
// sha1bc_in_if
// Message word channel: valid/ready handshake with word and framing flags.
// ----------------------------------------------------------------------------
interface sha1bc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        start_message;
  logic        end_message;

  modport source (output valid, message_word, start_message, end_message, input ready);
  modport sink   (input valid, message_word, start_message, end_message, output ready);
endinterface

### rtl/sha1bc_out_if.sv
// ----------------------------------------------------------------------------
// sha1bc_out_if
// Digest channel: valid/ready handshake carrying the five hash words.
// ----------------------------------------------------------------------------
interface sha1bc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, output ready);
endinterface

### rtl/sha1_block_compression_top.sv
// Flow: the 16 words of a block are taken in ST_COLLECT, then the 80 rounds run in ST_ROUND
//   and the chaining add in ST_ADD, where a final block's digest loads unless stalled; no word
//   is taken meanwhile. One shared round unit does one round per cycle; out_valid is registered.
// Stalls: a final block whose digest finds the previous one still unread holds the input
//   until out_ready takes the older digest.
// Reset (rst_n low, synchronous): control clears, chaining value reloads the SHA-1 initial value.
// ----------------------------------------------------------------------------
// sha1_block_compression_top
// SHA-1 block compression engine with message word input and digest output.
// ----------------------------------------------------------------------------
module sha1_block_compression_top
  import sha1bc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sha1bc_in_if.sink  in_ch,
  sha1bc_out_if.source out_ch
);

  cmd_t  cmd;
  hash_t digest;

  // Sequencer
  sha1bc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_start  (in_ch.start_message),
    .in_end    (in_ch.end_message),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath
  sha1bc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_word (in_ch.message_word),
    .digest  (digest)
  );

  assign out_ch.digest_word0 = digest[0];
  assign out_ch.digest_word1 = digest[1];
  assign out_ch.digest_word2 = digest[2];
  assign out_ch.digest_word3 = digest[3];
  assign out_ch.digest_word4 = digest[4];

  // No request taken while rounds run
  a_no_accept_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> !in_ch.ready)
    else $error("request accepted during compression rounds");

  // The chaining add directly follows the last round
  a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_en |-> $past(cmd.round_en))
    else $error("chaining add without preceding round");

  // A digest load always presents a valid result next cycle
  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid)
    else $error("digest loaded but not presented");

  // Digest loads only at the end of a block
  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !in_ch.ready && !cmd.round_en)
    else $error("digest load outside block completion");

endmodule

### rtl/sha1bc_ctrl.sv
// ----------------------------------------------------------------------------
// sha1bc_ctrl
// Sequencer: counts words of a block, steps the 80 rounds, handles the
// final-block flag and the digest output register handshake.
// ----------------------------------------------------------------------------
module sha1bc_ctrl
  import sha1bc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_start,
  input  logic in_end,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_base;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             final_r, final_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign cnt_base  = in_start ? '0 : cnt_r;
  assign out_valid = out_valid_r;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      cnt_r       <= '0;
      rnd_r       <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    final_nxt     = final_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.phase     = PH_CHOOSE;

    unique case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_word = 1'b1;
          cmd.start     = in_start;
          cnt_nxt       = cnt_base + 1'b1;
          final_nxt     = (in_start ? 1'b0 : final_r) | in_end;
          if (cnt_base == CNT_W'(BLOCK_WORDS - 1)) begin
            cmd.init_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (rnd_r < RND_W'(PH1_START)) begin
          cmd.phase = PH_CHOOSE;
        end else if (rnd_r < RND_W'(PH2_START)) begin
          cmd.phase = PH_PARITY_A;
        end else if (rnd_r < RND_W'(PH3_START)) begin
          cmd.phase = PH_MAJORITY;
        end else begin
          cmd.phase = PH_PARITY_B;
        end
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
        if (!final_r) begin
          state_nxt = ST_COLLECT;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          final_nxt    = 1'b0;
          state_nxt    = ST_COLLECT;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the previous digest to drain
        if (out_free) begin
          cmd.out_load = 1'b1;
          final_nxt    = 1'b0;
          state_nxt    = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // Output valid: set on load, drop on take
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

### rtl/sha1bc_dp.sv
// ----------------------------------------------------------------------------
// sha1bc_dp
// Datapath: message schedule window, working variables with one round unit,
// chaining value and the digest output register.
// ----------------------------------------------------------------------------
module sha1bc_dp
  import sha1bc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  word_t in_word,
  output hash_t digest
);

  word_t [BLOCK_WORDS-1:0] win_r;
  hash_t                   chain_r;
  hash_t                   work_r;
  hash_t                   dig_r;
  hash_t                   sum;
  word_t                   w_new;
  word_t                   w_mix;
  word_t                   f_val;
  word_t                   tmp;
  word_t                   a, b, c, d, e;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  // Schedule expansion: window holds W[t..t+15], append W[t+16]
  assign w_mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

  // One SHA-1 round
  assign f_val = round_fn(cmd.phase, b, c, d);
  assign tmp   = {a[WORD_W-6:0], a[WORD_W-1:WORD_W-5]} + f_val + e + win_r[0]
                 + round_const(cmd.phase);

  // Final feed-forward sum
  always_comb begin
    for (int i = 0; i < HASH_WORDS; i++) begin
      sum[i] = chain_r[i] + work_r[i];
    end
  end

  // Schedule window: shift in message words or expanded words
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      win_r <= {in_word, win_r[BLOCK_WORDS-1:1]};
    end else if (cmd.round_en) begin
      win_r <= {w_new, win_r[BLOCK_WORDS-1:1]};
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.init_work) begin
      work_r <= cmd.start ? INIT_H : chain_r;
    end else if (cmd.round_en) begin
      work_r <= {d, c, {b[1:0], b[WORD_W-1:2]}, a, tmp};
    end
  end

  // Chaining value: reload on start, accumulate after the last round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= INIT_H;
    end else if (cmd.load_word && cmd.start) begin
      chain_r <= INIT_H;
    end else if (cmd.add_en) begin
      chain_r <= sum;
    end
  end

  // Digest register: take the fresh sum, or the held chain after a stall
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dig_r <= cmd.add_en ? sum : chain_r;
    end
  end

  assign digest = dig_r;

endmodule

### verif/sha1_block_compression_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_block_compression_checker
// Watches the message word and digest channels of the SHA-1 compression
// engine. It keeps its own chaining value and block buffer, runs the 80
// SHA-1 rounds itself when a block completes, queues the digest of each
// final block and compares it word by word with what the engine sends.
// ----------------------------------------------------------------------------
module sha1_block_compression_checker
  import sha1bc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  sha1bc_in_if  in_mon,
  sha1bc_out_if out_mon,
  output int    fail_count,
  output int    digests_pending
);

  localparam word_t K_CHOOSE   = 32'h5A827999;
  localparam word_t K_PARITY_A = 32'h6ED9EBA1;
  localparam word_t K_MAJORITY = 32'h8F1BBCDC;
  localparam word_t K_PARITY_B = 32'hCA62C1D6;

  hash_t                expected_digests[$];
  hash_t                chain_value;
  word_t                block_words[BLOCK_WORDS];
  logic [CNT_W-1:0]     word_idx;
  logic                 last_block;

  initial begin
    fail_count      = 0;
    digests_pending = 0;
  end

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // Expand the block, run all rounds and add the result into the chaining value
  function automatic hash_t compress(input hash_t h, input word_t blk[BLOCK_WORDS]);
    word_t  w[BLOCK_WORDS];
    word_t  a, b, c, d, e, f, k, sum;
    phase_t ph;
    hash_t  r;
    w = blk;
    a = h[0];
    b = h[1];
    c = h[2];
    d = h[3];
    e = h[4];
    for (int t = 0; t < ROUNDS; t++) begin
      if (t >= BLOCK_WORDS) begin
        w[t % 16] = rotl(w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16], 1);
      end
      ph = (t < PH1_START) ? PH_CHOOSE :
           (t < PH2_START) ? PH_PARITY_A :
           (t < PH3_START) ? PH_MAJORITY : PH_PARITY_B;
      case (ph)
        PH_CHOOSE: begin
          f = (b & c) | (~b & d);
          k = K_CHOOSE;
        end
        PH_PARITY_A: begin
          f = b ^ c ^ d;
          k = K_PARITY_A;
        end
        PH_MAJORITY: begin
          f = (b & c) | (b & d) | (c & d);
          k = K_MAJORITY;
        end
        default: begin
          f = b ^ c ^ d;
          k = K_PARITY_B;
        end
      endcase
      sum = rotl(a, 5) + f + e + w[t % 16] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    r[0] = h[0] + a;
    r[1] = h[1] + b;
    r[2] = h[2] + c;
    r[3] = h[3] + d;
    r[4] = h[4] + e;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns  digest check: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hash_t want;
    word_t got[HASH_WORDS];
    if (!rst_n) begin
      chain_value = INIT_H;
      word_idx    = '0;
      last_block  = 1'b0;
      expected_digests.delete();
    end else begin
      // Track each accepted word request
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.start_message) begin
          chain_value = INIT_H;
          word_idx    = '0;
          last_block  = 1'b0;
        end
        if (in_mon.end_message) last_block = 1'b1;
        block_words[word_idx] = in_mon.message_word;
        word_idx++;
        if (word_idx == 0) begin
          chain_value = compress(chain_value, block_words);
          if (last_block) begin
            expected_digests.push_back(chain_value);
            last_block = 1'b0;
          end
        end
      end
      // Compare each accepted digest with the oldest one waiting
      if (out_mon.valid && out_mon.ready) begin
        if (expected_digests.size() == 0) begin
          report_mismatch("digest sent while no final block was pending");
        end else begin
          want   = expected_digests.pop_front();
          got[0] = out_mon.digest_word0;
          got[1] = out_mon.digest_word1;
          got[2] = out_mon.digest_word2;
          got[3] = out_mon.digest_word3;
          got[4] = out_mon.digest_word4;
          for (int i = 0; i < HASH_WORDS; i++) begin
            if (got[i] !== want[i]) begin
              report_mismatch($sformatf("digest_word%0d got %08h, want %08h",
                                        i, got[i], want[i]));
            end
          end
        end
      end
    end
    digests_pending = expected_digests.size();
  end

endmodule

### verif/sha1_block_compression_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_block_compression_top_tb
// Feeds padded message words to the SHA-1 compression engine: one directed
// block at the word extremes and a partial block, then random messages, mostly well framed with
// some broken framing and noise mixed in. Both channels idle at random, and
// the digest side holds off once for a long stretch. The checker predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sha1_block_compression_top_tb
  import sha1bc_pkg::*;
;

  localparam int WORD_TARGET  = 850;
  localparam int QUIET_AFTER  = 700;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   digests_pending;
  int   words_sent;
  bit   quiet;
  bit   hold_req;
  bit   hold_done;

  sha1bc_in_if  in_ch ();
  sha1bc_out_if out_ch ();

  sha1_block_compression_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_block_compression_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .digests_pending (digests_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one word request, idling first at random; return at the falling edge
  task automatic send_word(input word_t word, input bit start, input bit last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.message_word  <= word;
    in_ch.start_message <= start;
    in_ch.end_message   <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
    if (words_sent >= HOLD_AT) hold_req = 1'b1;
    if (words_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  // Send one random message; well framed unless noise is picked
  task automatic send_message(input bit well_formed_only);
    int kind;
    int nblocks;
    int end_pos;
    int len;
    kind = well_formed_only ? 0 : $urandom_range(0, 9);
    nblocks = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1;
    end_pos = $urandom_range(0, 15);
    if (kind <= 7) begin
      // Framed message; the last kind continues the previous chaining value
      for (int b = 0; b < nblocks; b++) begin
        for (int w = 0; w < BLOCK_WORDS; w++) begin
          send_word($urandom(), (kind != 7) && b == 0 && w == 0,
                    (b == nblocks - 1) && (w == end_pos || $urandom_range(0, 7) == 0));
        end
      end
    end else begin
      // Broken block or noise with random framing flags
      len = (kind == 8) ? $urandom_range(1, 15) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        send_word($urandom(), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
      end
    end
  endtask

  // Digest side: random stalls, one long hold-off, none at the end
  initial begin
    int n;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.message_word  = '0;
    in_ch.start_message = 1'b0;
    in_ch.end_message   = 1'b0;
    words_sent          = 0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Alternating extremes, end flag on an early word of the block only
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      send_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0, i == 3);
    end
    // Partial final block, dropped by the start of the next message
    send_word(32'h8000_0000, 1'b0, 1'b0);
    send_word(32'h0000_0001, 1'b0, 1'b1);
    send_word(32'hA5A5_A5A5, 1'b0, 1'b0);
    send_message(1'b1);

    // Random messages
    while (words_sent < WORD_TARGET) begin
      send_message(1'b0);
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding digests, then let the engine settle
    wait (digests_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha1_block_compression_top regression: pass");
    end else begin
      $display("sha1_block_compression_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("sha1_block_compression_top regression: fail");
    $finish;
  end

endmodule
